@@ rtl/coincidence_scaler_card_core_defines.svh @@
// Assertion macros for the coincidence scaler card core.
// Included by the top level; no other dependencies.
`ifndef COINCIDENCE_SCALER_CARD_CORE_DEFINES_SVH
`define COINCIDENCE_SCALER_CARD_CORE_DEFINES_SVH

// Property that must hold in the cycle after the antecedent.
`define CSC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("csc assertion failed");

// Property that must hold in the same cycle as the antecedent.
`define CSC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("csc assertion failed");

`endif

@@ rtl/csc_pkg.sv @@
// Shared types and register map constants for the scaler card core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package csc_pkg;

  // Fixed field widths of the bus interface.
  localparam int DATA_W      = 32;
  localparam int HALF_W      = 48;
  localparam int SEL_W       = 7;
  localparam int SECTION_W   = 2;
  localparam int CODE_W      = 12;
  localparam int PANEL_W     = 5;
  localparam int LINE_MASK_W = 24;

  // Request opcodes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register byte offsets.
  localparam logic [5:0] OFF_CLEAR     = 6'h00;
  localparam logic [5:0] OFF_COUNTER   = 6'h04;
  localparam logic [5:0] OFF_COUNT_ON  = 6'h08;
  localparam logic [5:0] OFF_COUNT_OFF = 6'h0c;
  localparam logic [5:0] OFF_SELECT    = 6'h10;
  localparam logic [5:0] OFF_DAC_LATCH = 6'h14;
  localparam logic [5:0] OFF_DAC_STROBE = 6'h18;
  localparam logic [5:0] OFF_PANEL     = 6'h28;
  localparam logic [5:0] OFF_GATE_ON   = 6'h2c;
  localparam logic [5:0] OFF_GATE_OFF  = 6'h30;
  localparam logic [5:0] OFF_SCRATCH_RD = 6'h34;
  localparam logic [5:0] OFF_SCRATCH   = 6'h38;

  // Bit position of the section field in a DAC latch write.
  localparam int SECTION_LSB = 12;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [5:0]        offset;
    logic [DATA_W-1:0] write_data;
    logic [HALF_W-1:0] hits_lower;
    logic [HALF_W-1:0] hits_upper;
    logic              trigger_hit;
  } csc_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]      read_data;
    logic                   dac_strobe;
    logic [SECTION_W-1:0]   dac_section;
    logic [LINE_MASK_W-1:0] dac_line_mask;
    logic [CODE_W-1:0]      dac_code;
    logic [PANEL_W-1:0]     front_panel_select;
    logic                   gate_on;
    logic                   counting_on;
  } csc_rsp_t;

  // Per-lane control: clear all, or count one hit.
  typedef struct packed {
    logic clr;
    logic inc;
  } csc_lane_ctl_t;

endpackage

@@ rtl/csc_lane.sv @@
// One counter lane: a wrapping counter with a sticky overflow flag.
// Depends on csc_pkg for the lane control struct.
`timescale 1ns / 1ps

module csc_lane #(
  parameter int COUNT_BITS = 19
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  csc_pkg::csc_lane_ctl_t  ctl,
  output logic [COUNT_BITS:0]     word
);
  import csc_pkg::*;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;

  // Clear has priority; an increment from all ones wraps and sets overflow.
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (ctl.clr) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (ctl.inc) begin
      count_nxt = count_r + 1'b1;
      if (&count_r) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign word = {ovf_r, count_r};

endmodule

@@ rtl/csc_merge.sv @@
// Readback merge: picks the selected lane word, or zero past the last lane.
// Depends on csc_pkg for the selection width.
`timescale 1ns / 1ps

module csc_merge #(
  parameter int NUM_CNT    = 97,
  parameter int COUNT_BITS = 19
) (
  input  logic [NUM_CNT-1:0][COUNT_BITS:0] words,
  input  logic [csc_pkg::SEL_W-1:0]        sel,
  output logic [COUNT_BITS:0]              word
);
  import csc_pkg::*;

  localparam int IDX_W = $clog2(NUM_CNT);

  logic in_range;

  // A selection at or beyond the lane count reads as zero.
  assign in_range = ({1'b0, sel} < (SEL_W + 1)'(NUM_CNT));

  always_comb begin
    if (in_range) begin
      word = words[sel[IDX_W-1:0]];
    end else begin
      word = '0;
    end
  end

endmodule

@@ rtl/coincidence_scaler_card_core.sv @@
// Top level of the scaler card core: register map, counter lanes, readback.
// Depends on csc_pkg, csc_lane, csc_merge and the assertion macro header.
//
// Usage:
//   A request is taken at a rising clock edge where start is high and busy
//   is low. It carries an opcode (bus write, bus read or counting tick), a
//   byte offset, a write word, 96 hit flags and the trigger hit flag.
//   Exactly one response follows for every request, on out_rsp, marked by
//   out_valid for a single cycle; both are registered at the request edge.
//   Throughput is one request per clock while busy is low: every counter
//   has a lane of its own that adds its hit in the same edge, and the
//   readback multiplexer over all lanes is the only shared path.
//   Status fields in the response show the state after the request.
//   Reset (rst_n low, synchronous) clears all counters, flags and control
//   registers, but not the response payload; busy is high while reset is held.
//   The receiver cannot stall: each response is on the ports for one
//   cycle only and must be taken then.
`timescale 1ns / 1ps
`include "coincidence_scaler_card_core_defines.svh"

module coincidence_scaler_card_core #(
  parameter int NUM_CHANNELS = 96,
  parameter int COUNT_BITS   = 19,
  parameter int DAC_LINES    = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  csc_pkg::csc_req_t  in_req,
  output logic               out_valid,
  output csc_pkg::csc_rsp_t  out_rsp
);
  import csc_pkg::*;

  localparam int NUM_CNT = NUM_CHANNELS + 1;
  localparam logic [LINE_MASK_W-1:0] LINE_MASK = LINE_MASK_W'((1 << DAC_LINES) - 1);

  logic accept;
  logic is_write, is_read, is_tick;

  logic [SEL_W-1:0]     sel_r, sel_nxt;
  logic                 cnt_en_r, cnt_en_nxt;
  logic                 gate_r, gate_nxt;
  logic [SECTION_W-1:0] section_r, section_nxt;
  logic [CODE_W-1:0]    code_r, code_nxt;
  logic [PANEL_W-1:0]   panel_r, panel_nxt;
  logic [DATA_W-1:0]    scratch_r, scratch_nxt;

  logic     out_valid_r;
  csc_rsp_t rsp_r, rsp_nxt;

  logic [2*HALF_W-1:0]               hits_all;
  logic [NUM_CNT-1:0]                inc_vec;
  logic                              clr_all;
  logic [NUM_CNT-1:0][COUNT_BITS:0]  lane_words;
  logic [COUNT_BITS:0]               sel_word;

  // Requests are refused only while reset is held.
  assign busy     = ~rst_n;
  assign accept   = start & ~busy;
  assign is_write = (in_req.opcode == OP_WRITE);
  assign is_read  = (in_req.opcode == OP_READ);
  assign is_tick  = (in_req.opcode == OP_TICK);

  // Counter lanes: every channel plus the trigger counter at the top index.
  assign hits_all = {in_req.hits_upper, in_req.hits_lower};
  assign inc_vec  = {in_req.trigger_hit, hits_all[NUM_CHANNELS-1:0]};
  assign clr_all  = accept & is_write & (in_req.offset == OFF_CLEAR);

  for (genvar g = 0; g < NUM_CNT; g++) begin : g_lane
    csc_lane_ctl_t ctl;
    assign ctl.clr = clr_all;
    assign ctl.inc = accept & is_tick & cnt_en_r & inc_vec[g];
    csc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .word (lane_words[g])
    );
  end

  // Readback of the selected counter.
  csc_merge #(.NUM_CNT(NUM_CNT), .COUNT_BITS(COUNT_BITS)) u_merge (
    .words(lane_words),
    .sel  (sel_r),
    .word (sel_word)
  );

  // Register map writes and response assembly.
  always_comb begin
    sel_nxt     = sel_r;
    cnt_en_nxt  = cnt_en_r;
    gate_nxt    = gate_r;
    section_nxt = section_r;
    code_nxt    = code_r;
    panel_nxt   = panel_r;
    scratch_nxt = scratch_r;
    rsp_nxt     = '0;
    if (is_write) begin
      unique case (in_req.offset)
        OFF_COUNT_ON:  cnt_en_nxt = 1'b1;
        OFF_COUNT_OFF: cnt_en_nxt = 1'b0;
        OFF_SELECT:    sel_nxt = in_req.write_data[SEL_W-1:0];
        OFF_DAC_LATCH: begin
          section_nxt = in_req.write_data[SECTION_LSB +: SECTION_W];
          code_nxt    = in_req.write_data[CODE_W-1:0];
        end
        OFF_DAC_STROBE: begin
          rsp_nxt.dac_strobe    = 1'b1;
          rsp_nxt.dac_line_mask = in_req.write_data[LINE_MASK_W-1:0] & LINE_MASK;
        end
        OFF_PANEL:     panel_nxt = in_req.write_data[PANEL_W-1:0];
        OFF_GATE_ON:   gate_nxt = 1'b1;
        OFF_GATE_OFF:  gate_nxt = 1'b0;
        OFF_SCRATCH:   scratch_nxt = in_req.write_data;
        default: ;
      endcase
    end else if (is_read) begin
      if (in_req.offset == OFF_COUNTER) begin
        rsp_nxt.read_data = DATA_W'(sel_word);
      end else if (in_req.offset == OFF_SCRATCH_RD) begin
        rsp_nxt.read_data = scratch_r;
      end
    end
    rsp_nxt.dac_section        = section_nxt;
    rsp_nxt.dac_code           = code_nxt;
    rsp_nxt.front_panel_select = panel_nxt;
    rsp_nxt.gate_on            = gate_nxt;
    rsp_nxt.counting_on        = cnt_en_nxt;
  end

  // Control state and response register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= '0;
      cnt_en_r    <= 1'b0;
      gate_r      <= 1'b0;
      section_r   <= '0;
      code_r      <= '0;
      panel_r     <= '0;
      scratch_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        sel_r     <= sel_nxt;
        cnt_en_r  <= cnt_en_nxt;
        gate_r    <= gate_nxt;
        section_r <= section_nxt;
        code_r    <= code_nxt;
        panel_r   <= panel_nxt;
        scratch_r <= scratch_nxt;
      end
    end
  end

  // Response payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // Every accepted request gets exactly one response in the next cycle.
  `CSC_ASSERT_NEXT(a_rsp_follows, clk, rst_n, accept, out_valid)
  `CSC_ASSERT_NEXT(a_no_extra_rsp, clk, rst_n, !accept, !out_valid)
  // An enable write shows up as counting on in its response.
  `CSC_ASSERT_NEXT(a_count_on, clk, rst_n,
    accept && is_write && (in_req.offset == OFF_COUNT_ON),
    cnt_en_r && out_rsp.counting_on)

endmodule
